/* rtl/dpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared constants and binary32 normalise/round helpers for the dot product.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int FP_W  = 32;
    localparam int SIG_W = 50;  // working significand, hidden bit at SIG_W-1

    localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [FP_W-1:0] POS_ZERO  = 32'h0000_0000;
    localparam logic [FP_W-1:0] EXP_INF   = 32'h7F80_0000;

    // leading zero count over the working significand
    function automatic logic [5:0] lzc(input logic [SIG_W-1:0] sig);
        logic [5:0] cnt;
        logic       found;
        cnt   = 6'd0;
        found = 1'b0;
        for (int i = SIG_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (sig[i]) begin
                    found = 1'b1;
                end else begin
                    cnt = cnt + 6'd1;
                end
            end
        end
        return cnt;
    endfunction

    // value = sig / 2^(SIG_W-1) * 2^(expo - 127); round to nearest even
    function automatic logic [FP_W-1:0] round_pack(
        input logic              sign,
        input logic signed [10:0] expo,
        input logic [SIG_W-1:0]  sig
    );
        logic [5:0]         lz;
        logic [SIG_W-1:0]   s1;
        logic [SIG_W-1:0]   s2;
        logic signed [10:0] e1;
        logic [10:0]        rsh;
        logic [7:0]         e2;
        logic               lost;
        logic               guard;
        logic               sticky;
        logic               inc;
        logic [FP_W-1:0]    r;
        lz   = lzc(sig);
        s1   = sig << lz;
        e1   = expo - $signed({5'b0, lz});
        lost = 1'b0;
        rsh  = 11'd0;
        if (sig == '0) begin
            return {sign, 31'b0};
        end
        if (e1 >= 11'sd255) begin
            return {sign, EXP_INF[30:0]};
        end
        if (e1 < 11'sd1) begin
            // gradual underflow
            rsh = 11'(11'sd1 - e1);
            if (rsh >= 11'(SIG_W)) begin
                s2   = '0;
                lost = 1'b1;
            end else begin
                s2   = s1 >> rsh[5:0];
                lost = |(s1 & ~({SIG_W{1'b1}} << rsh[5:0]));
            end
            e2 = 8'd0;
        end else begin
            s2 = s1;
            e2 = e1[7:0];
        end
        guard  = s2[SIG_W-25];
        sticky = (|s2[SIG_W-26:0]) | lost;
        inc    = guard & (sticky | s2[SIG_W-24]);
        r      = {1'b0, e2, s2[SIG_W-2:SIG_W-24]} + {31'b0, inc};
        if (r >= EXP_INF) begin
            return {sign, EXP_INF[30:0]};
        end
        return {sign, r[30:0]};
    endfunction

endpackage

/* rtl/dpf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_in_if / dpf_out_if
// Valid/ready request channels for the element pairs and the results.
// ----------------------------------------------------------------------------
interface dpf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic        last_element;
    logic        empty_vector;

    modport source(output valid, x_value, y_value, last_element, empty_vector, input ready);
    modport sink(input valid, x_value, y_value, last_element, empty_vector, output ready);
endinterface

interface dpf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_result;

    modport source(output valid, dot_result, input ready);
    modport sink(input valid, dot_result, output ready);
endinterface

/* rtl/dot_product_float32.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_float32
// Streaming binary32 dot product: rounded multiply, then rounded accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one (x_value, y_value) pair per request, with last_element
//   closing a vector and empty_vector standing for a zero-length one.
//   o_out carries one dot_result per closed or empty vector.
// Throughput: one request per cycle while the pipeline does not hold. The
//   product is registered after the multiplier; the adder and the running-sum register form the
//   single feedback loop, closed every cycle.
// Result path: the closing request passes the input register (r_a), the
//   product register (r_b) and the output register before o_out.valid rises.
// Reset: clears all valid flags and sets the running sum to +0.0.
// Stall: a result waits in the output register; pairs that produce no result
//   keep flowing. Only when a second result reaches the adder while the
//   first still waits does the pipeline hold, and i_in.ready drops once the
//   input register is full as well.
// ----------------------------------------------------------------------------
module dot_product_float32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpf_in_if.sink      i_in,
    dpf_out_if.source   o_out
);
    import dpf_pkg::*;

    logic            r_a_valid, r_a_last, r_a_empty;
    logic [FP_W-1:0] r_a_x, r_a_y;
    logic            r_b_valid, r_b_last, r_b_empty;
    logic [FP_W-1:0] r_b_prod;
    logic [FP_W-1:0] r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    logic [FP_W-1:0] r_out_data, n_out_data;
    logic [FP_W-1:0] prod, sum;
    logic            stall_b, a_load, emit;

    dpf_fmul u_fmul (.i_a(r_a_x), .i_b(r_a_y), .o_p(prod));
    dpf_fadd u_fadd (.i_a(r_acc), .i_b(r_b_prod), .o_s(sum));

    assign stall_b = r_b_valid && (r_b_last || r_b_empty) && r_out_valid && !o_out.ready;
    assign a_load  = !r_a_valid || !stall_b;
    assign emit    = r_b_valid && !stall_b && (r_b_last || r_b_empty);

    assign i_in.ready       = a_load;
    assign o_out.valid      = r_out_valid;
    assign o_out.dot_result = r_out_data;

    always_comb begin
        n_acc       = r_acc;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !o_out.ready;
        if (r_b_valid && !stall_b) begin
            if (r_b_empty) begin
                n_acc      = POS_ZERO;
                n_out_data = POS_ZERO;
            end else if (r_b_last) begin
                n_acc      = POS_ZERO;
                n_out_data = sum;
            end else begin
                n_acc = sum;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= POS_ZERO;
        end else begin
            if (a_load) begin
                r_a_valid <= i_in.valid;
            end
            if (!stall_b) begin
                r_b_valid <= r_a_valid;
            end
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_x     <= i_in.x_value;
            r_a_y     <= i_in.y_value;
            r_a_last  <= i_in.last_element;
            r_a_empty <= i_in.empty_vector;
        end
        if (!stall_b) begin
            r_b_prod  <= prod;
            r_b_last  <= r_a_last;
            r_b_empty <= r_a_empty;
        end
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_valid && (r_acc == POS_ZERO)))
        else $error("closing request did not post a result and clear the sum");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_empty && !stall_b) |=> (r_out_data == POS_ZERO))
        else $error("empty vector did not give +0.0");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_a_valid && r_b_valid && r_out_valid))
        else $error("input held off with a free pipeline slot");
`endif

endmodule

/* rtl/dpf_fmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_fmul
// Binary32 multiply, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module dpf_fmul (
    input  logic [dpf_pkg::FP_W-1:0] i_a,
    input  logic [dpf_pkg::FP_W-1:0] i_b,
    output logic [dpf_pkg::FP_W-1:0] o_p
);
    import dpf_pkg::*;

    logic [7:0]         exp_a, exp_b, ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        prod;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sign;
    logic signed [10:0] expo;

    always_comb begin
        exp_a  = i_a[30:23];
        exp_b  = i_b[30:23];
        nan_a  = (exp_a == 8'hFF) && (i_a[22:0] != '0);
        nan_b  = (exp_b == 8'hFF) && (i_b[22:0] != '0);
        inf_a  = (exp_a == 8'hFF) && (i_a[22:0] == '0);
        inf_b  = (exp_b == 8'hFF) && (i_b[22:0] == '0);
        zero_a = (i_a[30:0] == '0);
        zero_b = (i_b[30:0] == '0);
        sign   = i_a[31] ^ i_b[31];
        ea     = (exp_a == 8'd0) ? 8'd1 : exp_a;
        eb     = (exp_b == 8'd0) ? 8'd1 : exp_b;
        ma     = {exp_a != 8'd0, i_a[22:0]};
        mb     = {exp_b != 8'd0, i_b[22:0]};
        prod   = ma * mb;
        expo   = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            o_p = CANON_NAN;
        end else if (inf_a || inf_b) begin
            o_p = {sign, EXP_INF[30:0]};
        end else begin
            o_p = round_pack(sign, expo, {prod, 2'b00});
        end
    end

endmodule

/* rtl/dpf_fadd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_fadd
// Binary32 add, round to nearest even; any NaN out is the canonical one.
// ----------------------------------------------------------------------------
module dpf_fadd (
    input  logic [dpf_pkg::FP_W-1:0] i_a,
    input  logic [dpf_pkg::FP_W-1:0] i_b,
    output logic [dpf_pkg::FP_W-1:0] o_s
);
    import dpf_pkg::*;

    logic [FP_W-1:0]    big, sml;
    logic [7:0]         eb_big, eb_sml, d;
    logic [SIG_W-1:0]   m_big, m_sml, shifted, sum;
    logic               st, nan_a, nan_b, inf_a, inf_b, sign;
    logic signed [10:0] expo;

    always_comb begin
        nan_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
        nan_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        inf_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] == '0);
        inf_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] == '0);
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d      = eb_big - eb_sml;
        m_big  = {1'b0, big[30:23] != 8'd0, big[22:0], 25'b0};
        m_sml  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'b0};
        if (d >= 8'(SIG_W)) begin
            shifted = '0;
            st      = |m_sml;
        end else begin
            shifted = m_sml >> d[5:0];
            st      = |(m_sml & ~({SIG_W{1'b1}} << d[5:0]));
        end
        shifted[0] = shifted[0] | st;
        if (big[31] == sml[31]) begin
            sum = m_big + shifted;
        end else begin
            sum = m_big - shifted;
        end
        // exact zero: +0 unless both operands negative
        sign = (sum == '0) ? (i_a[31] & i_b[31]) : big[31];
        expo = $signed({3'b0, eb_big}) + 11'sd1;
        if (nan_a || nan_b || (inf_a && inf_b && (i_a[31] != i_b[31]))) begin
            o_s = CANON_NAN;
        end else if (inf_a) begin
            o_s = i_a;
        end else if (inf_b) begin
            o_s = i_b;
        end else begin
            o_s = round_pack(sign, expo, sum);
        end
    end

endmodule
